[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// short forms for the concurrent checks of the arm arbiter
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/hrras_pkg.sv]
// ----------------------------------------------------------------------------
// hrras_pkg
// types, constants and command structs shared by the arm arbiter modules
// ----------------------------------------------------------------------------
package hrras_pkg;

  localparam int MAX_ARMS = 64;
  localparam int POS_W    = $clog2(MAX_ARMS);
  localparam int IDX_W    = 6;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  // register indexes
  localparam logic [0:0] REG_SELECT_SEED = 1'b0;

  // operation codes
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_SEND    = 2'd1;

  localparam logic [63:0] MIX_MUL_A      = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B      = 64'h94d049bb133111eb;
  localparam logic [63:0] GOLDEN_STEP    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] CHANNEL_SALT   = 64'hd6e8feb86659fd93;
  localparam logic [63:0] DIRECTION_SALT = 64'ha5a356341f125d3b;
  localparam logic [63:0] ORDINAL_SALT   = 64'h8cb92d3b5e4f1a77;
  localparam logic [63:0] SEED_AT_RESET  = 64'h6a09e667f3bcc909;

  typedef struct packed {
    logic [1:0]  operation;
    logic        arm_ready;
    logic [31:0] channel_id;
    logic [15:0] arm_ordinal;
    logic        last_arm;
  } req_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] selected_index;
  } res_word_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_GEN,
    ST_MA0,
    ST_MA1,
    ST_MA2,
    ST_MA3,
    ST_XB,
    ST_MB0,
    ST_MB1,
    ST_MB2,
    ST_MB3,
    ST_SEED,
    ST_CH0,
    ST_CH1,
    ST_CH2,
    ST_CH3,
    ST_CH4,
    ST_HMIX,
    ST_SCORE,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    A_X_LO,
    A_X_HI,
    A_CHAN,
    A_ORD
  } a_sel_t;

  typedef enum logic [1:0] {
    K_MIX_A,
    K_MIX_B,
    K_CHAN,
    K_ORD
  } k_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    X_HOLD,
    X_GEN,
    X_MIX27,
    X_HASH
  } x_op_t;

  typedef enum logic [1:0] {
    H_HOLD,
    H_INIT,
    H_XOR
  } hash_op_t;

  typedef struct packed {
    a_sel_t   a_sel;
    k_sel_t   k_sel;
    logic     k_hi;
    acc_op_t  acc_op;
    x_op_t    x_op;
    hash_op_t hash_op;
    logic     arm_load;
    logic     seed_load;
    logic     score_upd;
    logic     emit;
    logic     round_end;
    logic     advance;
  } dp_cmd_t;

  typedef struct packed {
    logic arm_live;
    logic have;
    logic last;
    logic res_busy;
  } dp_stat_t;

  function automatic logic [63:0] k_value(input k_sel_t sel);
    logic [63:0] k;
    case (sel)
      K_MIX_A: k = MIX_MUL_A;
      K_MIX_B: k = MIX_MUL_B;
      K_CHAN:  k = CHANNEL_SALT;
      K_ORD:   k = ORDINAL_SALT;
      default: k = MIX_MUL_A;
    endcase
    return k;
  endfunction

endpackage

[rtl/hashed_random_ready_arm_select_top.sv]
// ----------------------------------------------------------------------------
// hashed_random_ready_arm_select_top
// randomised pick of one ready arm per select round, splitmix64 scoring
// ----------------------------------------------------------------------------
// channel   signals                                   carries
// req       req_valid / req_ready / req_word          one arm of a round
// res       res_valid / res_ready / res_word          winner of a round
// cfg       psel penable pwrite paddr pwdata prdata   select_seed at 0x0
//
// an arm that is not ready skips the multiplier; a ready arm runs the salt products
// and the mix, and the first ready arm of a round first draws the round seed; all
// go through the single 32x32 multiplier, four steps per 64-bit product, two products per mix
// one arm in flight at a time; a round's last arm waits in the finish step
// while an earlier result is still held on res
// rst is synchronous and returns the generator to its reset seed
// ----------------------------------------------------------------------------
module hashed_random_ready_arm_select_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  hrras_pkg::req_word_t              req_word,
  output logic                              res_valid,
  input  logic                              res_ready,
  output hrras_pkg::res_word_t              res_word,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrras_pkg::PADDR_W-1:0]     paddr,
  input  logic [hrras_pkg::PDATA_W-1:0]     pwdata,
  output logic [hrras_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  hrras_pkg::dp_cmd_t  cmd;
  hrras_pkg::dp_stat_t stat;
  logic                cfg_wr;
  logic                reg_hit;
  logic [63:0]         seed_value;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[hrras_pkg::PADDR_W-1:3] == hrras_pkg::REG_SELECT_SEED);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? seed_value : '0;

  hrras_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hrras_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_word   (req_word),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_word   (res_word),
    .cfg_wr     (cfg_wr),
    .cfg_data   (pwdata),
    .seed_value (seed_value)
  );

endmodule

[rtl/hrras_ctrl.sv]
// ----------------------------------------------------------------------------
// hrras_ctrl
// sequencer for one arm: seed draw, salt products, two-round mix, score
// ----------------------------------------------------------------------------
module hrras_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  hrras_pkg::dp_stat_t stat,
  output hrras_pkg::dp_cmd_t  cmd
);

  hrras_pkg::state_t state;
  hrras_pkg::state_t state_next;
  logic              phase_score;

  // multiplier constant for each step
  function automatic hrras_pkg::k_sel_t phase_mul_k(input hrras_pkg::state_t st);
    hrras_pkg::k_sel_t k;
    case (st)
      hrras_pkg::ST_MB0, hrras_pkg::ST_MB1, hrras_pkg::ST_MB2,
      hrras_pkg::ST_MB3: k = hrras_pkg::K_MIX_B;
      hrras_pkg::ST_CH0, hrras_pkg::ST_CH1: k = hrras_pkg::K_CHAN;
      hrras_pkg::ST_CH2, hrras_pkg::ST_CH3: k = hrras_pkg::K_ORD;
      default: k = hrras_pkg::K_MIX_A;
    endcase
    return k;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= hrras_pkg::ST_IDLE;
      phase_score <= 1'b0;
    end else begin
      state <= state_next;
      if (state == hrras_pkg::ST_GEN) begin
        phase_score <= 1'b0;
      end else if (state == hrras_pkg::ST_HMIX) begin
        phase_score <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hrras_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = hrras_pkg::ST_DECIDE;
        end
      end
      hrras_pkg::ST_DECIDE: begin
        if (!stat.arm_live) begin
          state_next = hrras_pkg::ST_FINISH;
        end else if (!stat.have) begin
          state_next = hrras_pkg::ST_GEN;
        end else begin
          state_next = hrras_pkg::ST_CH0;
        end
      end
      hrras_pkg::ST_GEN:  state_next = hrras_pkg::ST_MA0;
      hrras_pkg::ST_MA0:  state_next = hrras_pkg::ST_MA1;
      hrras_pkg::ST_MA1:  state_next = hrras_pkg::ST_MA2;
      hrras_pkg::ST_MA2:  state_next = hrras_pkg::ST_MA3;
      hrras_pkg::ST_MA3:  state_next = hrras_pkg::ST_XB;
      hrras_pkg::ST_XB:   state_next = hrras_pkg::ST_MB0;
      hrras_pkg::ST_MB0:  state_next = hrras_pkg::ST_MB1;
      hrras_pkg::ST_MB1:  state_next = hrras_pkg::ST_MB2;
      hrras_pkg::ST_MB2:  state_next = hrras_pkg::ST_MB3;
      hrras_pkg::ST_MB3: begin
        state_next = phase_score ? hrras_pkg::ST_SCORE : hrras_pkg::ST_SEED;
      end
      hrras_pkg::ST_SEED: state_next = hrras_pkg::ST_CH0;
      hrras_pkg::ST_CH0:  state_next = hrras_pkg::ST_CH1;
      hrras_pkg::ST_CH1:  state_next = hrras_pkg::ST_CH2;
      hrras_pkg::ST_CH2:  state_next = hrras_pkg::ST_CH3;
      hrras_pkg::ST_CH3:  state_next = hrras_pkg::ST_CH4;
      hrras_pkg::ST_CH4:  state_next = hrras_pkg::ST_HMIX;
      hrras_pkg::ST_HMIX: state_next = hrras_pkg::ST_MA0;
      hrras_pkg::ST_SCORE: state_next = hrras_pkg::ST_FINISH;
      hrras_pkg::ST_FINISH: begin
        // a round end waits for the result register to drain
        if (!(stat.last && stat.res_busy)) begin
          state_next = hrras_pkg::ST_IDLE;
        end
      end
      default: state_next = hrras_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready     = (state == hrras_pkg::ST_IDLE);
    cmd           = '0;
    cmd.a_sel     = hrras_pkg::A_X_LO;
    cmd.k_sel     = phase_mul_k(state);
    cmd.acc_op    = hrras_pkg::ACC_HOLD;
    cmd.x_op      = hrras_pkg::X_HOLD;
    cmd.hash_op   = hrras_pkg::H_HOLD;
    case (state)
      hrras_pkg::ST_IDLE: begin
        cmd.arm_load = req_valid;
      end
      hrras_pkg::ST_GEN: begin
        cmd.x_op = hrras_pkg::X_GEN;
      end
      // x * k mod 2^64 = xlo*klo + ((xlo*khi + xhi*klo) << 32)
      hrras_pkg::ST_MA0, hrras_pkg::ST_MB0: begin
        cmd.a_sel = hrras_pkg::A_X_LO;
      end
      hrras_pkg::ST_MA1, hrras_pkg::ST_MB1: begin
        cmd.a_sel  = hrras_pkg::A_X_LO;
        cmd.k_hi   = 1'b1;
        cmd.acc_op = hrras_pkg::ACC_LOAD;
      end
      hrras_pkg::ST_MA2, hrras_pkg::ST_MB2: begin
        cmd.a_sel  = hrras_pkg::A_X_HI;
        cmd.acc_op = hrras_pkg::ACC_ADD_HI;
      end
      hrras_pkg::ST_MA3, hrras_pkg::ST_MB3: begin
        cmd.acc_op = hrras_pkg::ACC_ADD_HI;
      end
      hrras_pkg::ST_XB: begin
        cmd.x_op = hrras_pkg::X_MIX27;
      end
      hrras_pkg::ST_SEED: begin
        cmd.seed_load = 1'b1;
      end
      hrras_pkg::ST_CH0: begin
        cmd.a_sel   = hrras_pkg::A_CHAN;
        cmd.hash_op = hrras_pkg::H_INIT;
      end
      hrras_pkg::ST_CH1: begin
        cmd.a_sel  = hrras_pkg::A_CHAN;
        cmd.k_hi   = 1'b1;
        cmd.acc_op = hrras_pkg::ACC_LOAD;
      end
      hrras_pkg::ST_CH2: begin
        cmd.a_sel  = hrras_pkg::A_ORD;
        cmd.acc_op = hrras_pkg::ACC_ADD_HI;
      end
      hrras_pkg::ST_CH3: begin
        cmd.a_sel   = hrras_pkg::A_ORD;
        cmd.k_hi    = 1'b1;
        cmd.acc_op  = hrras_pkg::ACC_LOAD;
        cmd.hash_op = hrras_pkg::H_XOR;
      end
      hrras_pkg::ST_CH4: begin
        cmd.acc_op = hrras_pkg::ACC_ADD_HI;
      end
      hrras_pkg::ST_HMIX: begin
        cmd.x_op = hrras_pkg::X_HASH;
      end
      hrras_pkg::ST_SCORE: begin
        cmd.score_upd = 1'b1;
      end
      hrras_pkg::ST_FINISH: begin
        cmd.emit      = stat.last && !stat.res_busy;
        cmd.round_end = stat.last && !stat.res_busy;
        cmd.advance   = !stat.last;
      end
      default: begin
        cmd.a_sel = hrras_pkg::A_X_LO;
      end
    endcase
  end

endmodule

[rtl/hrras_dp.sv]
// ----------------------------------------------------------------------------
// hrras_dp
// datapath: generator, shared 32x32 multiplier, score compare, result register
// ----------------------------------------------------------------------------
module hrras_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  hrras_pkg::dp_cmd_t   cmd,
  output hrras_pkg::dp_stat_t  stat,
  input  hrras_pkg::req_word_t req_word,
  output logic                 res_valid,
  input  logic                 res_ready,
  output hrras_pkg::res_word_t res_word,
  input  logic                 cfg_wr,
  input  logic [63:0]          cfg_data,
  output logic [63:0]          seed_value
);

  // generator and round state
  logic [63:0]                 gen;
  logic [63:0]                 round_key;
  logic                        have;
  logic [63:0]                 best;
  logic [hrras_pkg::POS_W-1:0] best_idx;
  logic [hrras_pkg::POS_W-1:0] pos;

  // working registers
  logic [63:0]          prod;
  logic [63:0]          acc;
  logic [63:0]          x;
  logic [63:0]          hash;
  hrras_pkg::req_word_t arm;

  logic [31:0] mul_a;
  logic [31:0] mul_k;
  logic [63:0] k_full;
  logic [63:0] gen_step;
  logic [63:0] mixed;
  logic [63:0] salted;
  logic        arm_live;
  logic        take_score;

  function automatic logic [63:0] mix30(input logic [63:0] v);
    return v ^ (v >> 30);
  endfunction

  function automatic logic [63:0] mix27(input logic [63:0] v);
    return v ^ (v >> 27);
  endfunction

  function automatic logic [63:0] mix31(input logic [63:0] v);
    return v ^ (v >> 31);
  endfunction

  always_comb begin
    case (cmd.a_sel)
      hrras_pkg::A_X_LO: mul_a = x[31:0];
      hrras_pkg::A_X_HI: mul_a = x[63:32];
      hrras_pkg::A_CHAN: mul_a = arm.channel_id;
      hrras_pkg::A_ORD:  mul_a = {16'h0000, arm.arm_ordinal};
      default:           mul_a = x[31:0];
    endcase
  end

  assign k_full   = hrras_pkg::k_value(cmd.k_sel);
  assign mul_k    = cmd.k_hi ? k_full[63:32] : k_full[31:0];
  assign gen_step = gen + hrras_pkg::GOLDEN_STEP;
  assign mixed    = mix31(acc);
  assign salted   = round_key ^ ((arm.operation == hrras_pkg::OP_SEND) ?
                                 hrras_pkg::DIRECTION_SALT : 64'h0);
  // invalid operations never count as ready
  assign arm_live = arm.arm_ready &&
                    (arm.operation == hrras_pkg::OP_RECEIVE ||
                     arm.operation == hrras_pkg::OP_SEND);
  // later arm wins a tie
  assign take_score = !have || (mixed >= best);

  assign stat.arm_live = arm_live;
  assign stat.have     = have;
  assign stat.last     = arm.last_arm;
  assign stat.res_busy = res_valid && !res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gen        <= hrras_pkg::SEED_AT_RESET;
      seed_value <= hrras_pkg::SEED_AT_RESET;
      round_key  <= '0;
      have       <= 1'b0;
      best       <= '0;
      best_idx   <= '0;
      pos        <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        seed_value <= cfg_data;
        gen        <= cfg_data;
      end else if (cmd.x_op == hrras_pkg::X_GEN) begin
        gen <= gen_step;
      end
      if (cmd.seed_load) begin
        round_key <= mixed;
      end
      if (cmd.score_upd) begin
        have <= 1'b1;
        if (take_score) begin
          best     <= mixed;
          best_idx <= pos;
        end
      end
      if (cmd.round_end) begin
        round_key <= '0;
        have      <= 1'b0;
        best      <= '0;
        best_idx  <= '0;
        pos       <= '0;
      end else if (cmd.advance) begin
        pos <= (pos == hrras_pkg::POS_W'(hrras_pkg::MAX_ARMS - 1)) ?
               '0 : pos + hrras_pkg::POS_W'(1);
      end
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_k;
    case (cmd.acc_op)
      hrras_pkg::ACC_LOAD:   acc <= prod;
      hrras_pkg::ACC_ADD_HI: acc <= acc + {prod[31:0], 32'h0000_0000};
      default:               acc <= acc;
    endcase
    case (cmd.x_op)
      hrras_pkg::X_GEN:   x <= mix30(gen_step);
      hrras_pkg::X_MIX27: x <= mix27(acc);
      hrras_pkg::X_HASH:  x <= mix30(hash ^ acc);
      default:            x <= x;
    endcase
    case (cmd.hash_op)
      hrras_pkg::H_INIT: hash <= salted;
      hrras_pkg::H_XOR:  hash <= hash ^ acc;
      default:           hash <= hash;
    endcase
    if (cmd.arm_load) begin
      arm <= req_word;
    end
    if (cmd.emit) begin
      res_word.found          <= have;
      res_word.selected_index <= have ? hrras_pkg::IDX_W'(best_idx) : '0;
    end
  end

endmodule

[rtl/hrras_chk.sv]
// ----------------------------------------------------------------------------
// hrras_chk
// port-level checks on the arm arbiter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrras_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input hrras_pkg::res_word_t res_word
);

  // a held result stays up and unchanged
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid)
  `ASSERT_NEXT(a_res_stable, clk, rst, res_valid && !res_ready, $stable(res_word))

  // one arm in flight: the cycle after an accept takes no further word
  `ASSERT_NEXT(a_one_word, clk, rst, !rst && req_valid && req_ready, !req_ready)

  // a round with no ready arm reports index zero
  `ASSERT_IMPLIES(a_none_zero, clk, rst, res_valid && !res_word.found, res_word.selected_index == '0)

endmodule

bind hashed_random_ready_arm_select_top hrras_chk u_chk (.*);

[verif/arm_select_checker.sv]
// ----------------------------------------------------------------------------
// arm_select_checker
// watches the arm, result and register ports of the ready-arm arbiter, keeps
// its own splitmix64 scoring of each select round and compares every winner
// ----------------------------------------------------------------------------
module arm_select_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  hrras_pkg::req_word_t          req_word,
  input  logic                          res_valid,
  input  logic                          res_ready,
  input  hrras_pkg::res_word_t          res_word,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hrras_pkg::PADDR_W-1:0] paddr,
  input  logic [hrras_pkg::PDATA_W-1:0] pwdata,
  input  logic                          pready,
  output int                            mismatches,
  output int                            pending,
  output int                            rounds_done,
  output int                            rounds_found,
  output int                            tie_wins,
  output int                            wrap_rounds,
  output int                            seed_loads
);
  timeunit 1ns;
  timeprecision 1ps;
  import hrras_pkg::*;

  localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'({REG_SELECT_SEED, 3'b000});

  res_word_t        winners_due[$];
  logic [63:0]      gen_state;
  logic [63:0]      round_key;
  logic [63:0]      best_score;
  logic             seen_live;
  logic [POS_W-1:0] arm_pos;
  logic [POS_W-1:0] best_pos;
  logic             round_wrapped;
  int               results_seen;

  function automatic logic [63:0] splitmix_finalise(input logic [63:0] v);
    logic [63:0] x;
    x = (v ^ (v >> 30)) * MIX_MUL_A;
    x = (x ^ (x >> 27)) * MIX_MUL_B;
    return x ^ (x >> 31);
  endfunction

  function automatic logic [63:0] arm_score(input logic [63:0] seed, input req_word_t w);
    logic [63:0] dir;
    dir = (w.operation == OP_SEND) ? 64'd1 : 64'd0;
    return splitmix_finalise(seed ^ (64'(w.channel_id) * CHANNEL_SALT) ^
                             (dir * DIRECTION_SALT) ^ (64'(w.arm_ordinal) * ORDINAL_SALT));
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    req_word_t   w;
    res_word_t   want;
    res_word_t   got;
    logic [63:0] s;
    logic        is_ready;
    logic        is_first;
    if (rst) begin
      gen_state     = SEED_AT_RESET;
      round_key     = '0;
      best_score    = '0;
      seen_live     = 1'b0;
      arm_pos       = '0;
      best_pos      = '0;
      round_wrapped = 1'b0;
      results_seen  = 0;
      mismatches    = 0;
      rounds_done   = 0;
      rounds_found  = 0;
      tie_wins      = 0;
      wrap_rounds   = 0;
      seed_loads    = 0;
      winners_due.delete();
      pending <= 0;
    end else begin
      // a seed write reloads only the generator, the drawn round seed stays
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR) begin
        gen_state = pwdata;
        seed_loads++;
      end

      if (res_valid && res_ready) begin
        got = res_word;
        results_seen++;
        if (winners_due.size() == 0) begin
          note_failure($sformatf("result %0d with no round closed: found=%0b index=%0d",
                                 results_seen, got.found, got.selected_index));
        end else begin
          want = winners_due.pop_front();
          if (got.found !== want.found)
            note_failure($sformatf("result %0d found: expected %0b got %0b",
                                   results_seen, want.found, got.found));
          if (got.selected_index !== want.selected_index)
            note_failure($sformatf("result %0d selected_index: expected %0d got %0d",
                                   results_seen, want.selected_index, got.selected_index));
        end
      end

      if (req_valid && req_ready) begin
        w = req_word;
        is_ready = w.arm_ready && (w.operation == OP_RECEIVE || w.operation == OP_SEND);
        if (is_ready) begin
          is_first = !seen_live;
          if (is_first) begin
            gen_state = gen_state + GOLDEN_STEP;
            round_key = splitmix_finalise(gen_state);
            seen_live = 1'b1;
          end
          s = arm_score(round_key, w);
          if (!is_first && s == best_score) tie_wins++;
          // later arm takes a tie
          if (is_first || s >= best_score) begin
            best_score = s;
            best_pos   = arm_pos;
          end
        end
        if (w.last_arm) begin
          want.found          = seen_live;
          want.selected_index = seen_live ? IDX_W'(best_pos) : '0;
          winners_due.push_back(want);
          rounds_done++;
          if (seen_live) rounds_found++;
          if (round_wrapped) wrap_rounds++;
          round_key     = '0;
          best_score    = '0;
          seen_live     = 1'b0;
          arm_pos       = '0;
          best_pos      = '0;
          round_wrapped = 1'b0;
        end else if (arm_pos == POS_W'(MAX_ARMS - 1)) begin
          arm_pos       = '0;
          round_wrapped = 1'b1;
        end else begin
          arm_pos = arm_pos + 1'b1;
        end
      end
      pending <= winners_due.size();
    end
  end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives select rounds of random arms into the ready-arm arbiter, with random
// gaps, result stalls and one long result hold-off, and reloads the generator
// seed between phases; the checker beside the block predicts each winner
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrras_pkg::*;

  localparam logic [1:0]         OP_BAD_A  = 2'd2;
  localparam logic [1:0]         OP_BAD_B  = 2'd3;
  localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'({REG_SELECT_SEED, 3'b000});
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 1500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASE_ARMS     = 250;
  localparam int PHASES         = 5;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  req_word_t          req_word  = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  res_word_t          res_word;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [PDATA_W-1:0] pwdata    = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int mismatches;
  int pending;
  int rounds_done;
  int rounds_found;
  int tie_wins;
  int wrap_rounds;
  int seed_loads;
  int arms_sent    = 0;
  int idle_cycles  = 0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  hashed_random_ready_arm_select_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  arm_select_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_word     (req_word),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_word     (res_word),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .pending      (pending),
    .rounds_done  (rounds_done),
    .rounds_found (rounds_found),
    .tie_wins     (tie_wins),
    .wrap_rounds  (wrap_rounds),
    .seed_loads   (seed_loads)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly no pause or a short one, now and then a long one
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic req_word_t arm_word(input logic [1:0] op, input logic rdy,
                                         input logic [31:0] chan, input logic [15:0] ord,
                                         input logic last);
    req_word_t w;
    w.operation   = op;
    w.arm_ready   = rdy;
    w.channel_id  = chan;
    w.arm_ordinal = ord;
    w.last_arm    = last;
    return w;
  endfunction

  task automatic drive_arm(input req_word_t w);
    int gap;
    gap = calm ? 0 : pick_pause();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (!req_ready);
    arms_sent++;
  endtask

  // drop valid, let every round close and the last arm drain out of the block
  task automatic settle_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] v);
    settle_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_round(input int len, input int ready_pct);
    req_word_t w;
    req_word_t prev;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 99) < 6) begin
        // repeat of the previous arm: same score, so the later one must win
        w = prev;
      end else begin
        if ($urandom_range(0, 99) < 82)
          w.operation = $urandom_range(0, 1) ? OP_SEND : OP_RECEIVE;
        else
          w.operation = $urandom_range(0, 1) ? OP_BAD_B : OP_BAD_A;
        w.arm_ready   = ($urandom_range(0, 99) < ready_pct);
        w.channel_id  = $urandom();
        w.arm_ordinal = 16'($urandom());
      end
      w.last_arm = (i == len - 1);
      drive_arm(w);
      prev = w;
    end
  endtask

  initial begin : stimulus
    logic [63:0] phase_seed [PHASES];
    int          r;
    int          len;
    int          ready_pct;
    int          target;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rounds on the reset seed
    drive_arm(arm_word(OP_RECEIVE, 1'b1, 32'h0000_0000, 16'h0000, 1'b1));
    drive_arm(arm_word(OP_BAD_A, 1'b1, 32'hffff_ffff, 16'hffff, 1'b0));
    drive_arm(arm_word(OP_BAD_B, 1'b1, 32'h0000_0000, 16'h0000, 1'b1));
    drive_arm(arm_word(OP_RECEIVE, 1'b0, 32'h0000_0001, 16'h0001, 1'b0));
    drive_arm(arm_word(OP_SEND, 1'b1, 32'hffff_ffff, 16'hffff, 1'b0));
    drive_arm(arm_word(OP_RECEIVE, 1'b1, 32'h5555_5555, 16'haaaa, 1'b0));
    drive_arm(arm_word(OP_SEND, 1'b0, 32'haaaa_aaaa, 16'h5555, 1'b1));
    drive_arm(arm_word(OP_SEND, 1'b1, 32'h0000_1234, 16'h0007, 1'b0));
    drive_arm(arm_word(OP_SEND, 1'b1, 32'h0000_1234, 16'h0007, 1'b0));
    drive_arm(arm_word(OP_RECEIVE, 1'b0, 32'h0000_1234, 16'h0007, 1'b1));
    drive_arm(arm_word(OP_RECEIVE, 1'b0, 32'h0000_0000, 16'h0000, 1'b1));
    // zero seed loaded mid-round: the drawn round seed stays
    drive_arm(arm_word(OP_SEND, 1'b1, 32'hdead_beef, 16'h0102, 1'b0));
    drive_arm(arm_word(OP_RECEIVE, 1'b0, 32'h0000_0000, 16'h0000, 1'b0));
    write_seed(64'h0);
    drive_arm(arm_word(OP_RECEIVE, 1'b1, 32'h0bad_f00d, 16'h0003, 1'b1));
    write_seed('1);
    drive_arm(arm_word(OP_SEND, 1'b1, 32'h0000_0000, 16'hffff, 1'b1));
    drive_arm(arm_word(OP_RECEIVE, 1'b1, 32'hffff_ffff, 16'h0000, 1'b1));
    write_seed(64'h1);
    drive_arm(arm_word(OP_BAD_A, 1'b1, 32'h0000_00ff, 16'h00ff, 1'b0));
    drive_arm(arm_word(OP_RECEIVE, 1'b1, 32'h0000_00ff, 16'h00ff, 1'b0));
    drive_arm(arm_word(OP_SEND, 1'b1, 32'h0000_00ff, 16'h00ff, 1'b1));

    phase_seed[0] = {$urandom(), $urandom()};
    phase_seed[1] = {$urandom(), $urandom()};
    phase_seed[2] = 64'h8000_0000_0000_0000;
    phase_seed[3] = SEED_AT_RESET;
    phase_seed[4] = {$urandom(), $urandom()};

    for (int p = 0; p < PHASES; p++) begin
      write_seed(phase_seed[p]);
      target = arms_sent + PHASE_ARMS;
      // one round long enough to wrap the arm position
      if (p == 1) run_round($urandom_range(MAX_ARMS + 1, MAX_ARMS + 40), 60);
      if (p == 2) hold_request = 1'b1;
      while (arms_sent < target) begin
        calm = ($urandom_range(0, 99) < 20);
        r = $urandom_range(0, 99);
        if (r < 65)      len = $urandom_range(1, 6);
        else if (r < 88) len = $urandom_range(7, 20);
        else if (r < 98) len = $urandom_range(21, MAX_ARMS);
        else             len = $urandom_range(MAX_ARMS + 1, MAX_ARMS + 36);
        case ($urandom_range(0, 4))
          0:       ready_pct = 0;
          1:       ready_pct = 15;
          2:       ready_pct = 50;
          3:       ready_pct = 90;
          default: ready_pct = 100;
        endcase
        run_round(len, ready_pct);
      end
    end
    calm = 1'b0;

    settle_idle();
    $display("run covered %0d arms in %0d rounds, %0d with a winner, %0d longer than %0d arms",
             arms_sent, rounds_done, rounds_found, wrap_rounds, MAX_ARMS);
    $display("later arm took %0d ties; %0d seed loads incl. zero, all ones and mid-round",
             tie_wins, seed_loads);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int on_cycles;
    int off_cycles;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      // long hold-off while arms keep coming, so the block backs up
      if (hold_request && !hold_done) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      on_cycles  = ($urandom_range(0, 99) < 20) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      off_cycles = pick_pause();
      res_ready <= 1'b1;
      repeat (on_cycles) @(posedge clk);
      if (off_cycles > 0) begin
        res_ready <= 1'b0;
        repeat (off_cycles) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready) ||
        (psel && penable && pwrite && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
